FILE: sv/accel_tilt_angles_with_tare_core_macros.svh
// Assertion macros for the tilt angle core.
`ifndef ACCEL_TILT_ANGLES_WITH_TARE_CORE_MACROS_SVH
`define ACCEL_TILT_ANGLES_WITH_TARE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define ATAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define ATAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/atat_pkg.sv
// Shared constants, types and the arctangent table of the tilt angle core.
package atat_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int IDX_W        = $clog2(TABLE_LEN);
  localparam int FRAC_BITS    = 16;
  localparam int CW           = 37;
  localparam int AW           = 33;
  localparam int KINV_BITS    = 20;
  localparam int LO_BITS      = 18;
  localparam int PW           = 56;

  localparam logic [KINV_BITS-1:0] KINV_Q20     = KINV_BITS'(636751);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(589824000);
  localparam logic signed [16:0]   ROLL_LIMIT   = 17'sd18000;
  localparam logic signed [16:0]   PITCH_LIMIT  = 17'sd9000;

  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROT1,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SETUP2,
    ST_ROT2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             clear_tare;
    logic             setup1;
    logic             setup2;
    logic             step;
    logic [IDX_W-1:0] step_idx;
    logic             mul_lo;
    logic             mul_hi;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       res_busy;
  } stat_t;

  // Arctangent of 2^-i in hundredths of a degree, scaled by 2^16.
  function automatic logic signed [AW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic signed [AW-1:0] v;
    unique case (idx)
      5'd0:    v = AW'(294912000);
      5'd1:    v = AW'(174096719);
      5'd2:    v = AW'(91987925);
      5'd3:    v = AW'(46694507);
      5'd4:    v = AW'(23437865);
      5'd5:    v = AW'(11730358);
      5'd6:    v = AW'(5866610);
      5'd7:    v = AW'(2933484);
      5'd8:    v = AW'(1466764);
      5'd9:    v = AW'(733385);
      5'd10:   v = AW'(366693);
      5'd11:   v = AW'(183346);
      5'd12:   v = AW'(91673);
      5'd13:   v = AW'(45837);
      5'd14:   v = AW'(22918);
      5'd15:   v = AW'(11459);
      5'd16:   v = AW'(5730);
      5'd17:   v = AW'(2865);
      5'd18:   v = AW'(1432);
      5'd19:   v = AW'(716);
      5'd20:   v = AW'(358);
      5'd21:   v = AW'(179);
      5'd22:   v = AW'(90);
      5'd23:   v = AW'(45);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/atat_sample_if.sv
// Request channel carrying one accelerometer sample and its mode.
interface atat_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, mode, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, mode, accel_x, accel_y, accel_z, output ready);
endinterface

FILE: sv/atat_result_if.sv
// Result channel carrying one pair of tared tilt angles.
interface atat_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_angle;
  logic signed [16:0] roll_angle;

  modport source (output valid, pitch_angle, roll_angle, input ready);
  modport sink (input valid, pitch_angle, roll_angle, output ready);
endinterface

FILE: sv/accel_tilt_angles_with_tare_core.sv
// Top level of the tilt angle core: roll and pitch from one sample, with tare offsets.
// A measure request presents its result after both CORDIC runs; capture gives none.
// Clear and unused modes give no result; the next request is taken once dispatch returns to idle.
// A measure or capture request holds off new ones through both 16-step CORDIC runs,
// and a measure result that waits for its sink stalls the next measure in its finish state until it is taken.
// Synchronous reset zeroes the tare offsets and drops any pending result.
`include "accel_tilt_angles_with_tare_core_macros.svh"

module accel_tilt_angles_with_tare_core (
  input  logic          clk,
  input  logic          rst,
  atat_sample_if.sink   sample,
  atat_result_if.source result
);

  atat_pkg::cmd_t  cmd;
  atat_pkg::stat_t stat;
  logic            in_acc;
  logic            measure_done;
  logic [6:0]      dp_ops;

  atat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atat_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .mode    (sample.mode),
    .accel_x (sample.accel_x),
    .accel_y (sample.accel_y),
    .accel_z (sample.accel_z),
    .result  (result)
  );

  assign in_acc       = sample.valid && sample.ready;
  assign measure_done = cmd.finish && (stat.mode == atat_pkg::MODE_MEASURE);
  assign dp_ops       = {cmd.setup1, cmd.setup2, cmd.step, cmd.mul_lo,
                         cmd.mul_hi, cmd.finish, cmd.clear_tare};

  `ATAT_ASSERT_NEXT(a_busy_after_accept, in_acc, !sample.ready, "sample taken while busy")
  `ATAT_ASSERT_NOW(a_no_overwrite, measure_done, !stat.res_busy, "pending result overwritten")
  `ATAT_ASSERT_NOW(a_one_op, 1'b1, $onehot0(dp_ops), "conflicting datapath commands")

endmodule

FILE: sv/atat_ctrl.sv
// Sequencer that steps the datapath through two CORDIC runs per measure or capture sample.
module atat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  atat_pkg::stat_t  stat,
  output atat_pkg::cmd_t   cmd
);

  localparam logic [atat_pkg::IDX_W-1:0] LAST_IDX = atat_pkg::IDX_W'(atat_pkg::NUM_STEPS - 1);

  atat_pkg::state_t state, state_next;
  logic [atat_pkg::IDX_W-1:0] cnt, cnt_next;
  logic run_mode;
  logic hold;

  assign run_mode = (stat.mode == atat_pkg::MODE_MEASURE) ||
                    (stat.mode == atat_pkg::MODE_CAPTURE);
  assign hold     = (stat.mode == atat_pkg::MODE_MEASURE) && stat.res_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atat_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atat_pkg::ST_IDLE:     if (in_valid) state_next = atat_pkg::ST_DISPATCH;
      atat_pkg::ST_DISPATCH: state_next = run_mode ? atat_pkg::ST_ROT1 : atat_pkg::ST_IDLE;
      atat_pkg::ST_ROT1:     if (cnt == LAST_IDX) state_next = atat_pkg::ST_MUL_LO;
      atat_pkg::ST_MUL_LO:   state_next = atat_pkg::ST_MUL_HI;
      atat_pkg::ST_MUL_HI:   state_next = atat_pkg::ST_SETUP2;
      atat_pkg::ST_SETUP2:   state_next = atat_pkg::ST_ROT2;
      atat_pkg::ST_ROT2:     if (cnt == LAST_IDX) state_next = atat_pkg::ST_FINISH;
      atat_pkg::ST_FINISH:   if (!hold) state_next = atat_pkg::ST_IDLE;
      default:               state_next = atat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if ((state == atat_pkg::ST_ROT1 || state == atat_pkg::ST_ROT2) && cnt != LAST_IDX) begin
      cnt_next = cnt + 1'b1;
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.step_idx = cnt;
    in_ready     = 1'b0;
    unique case (state)
      atat_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      atat_pkg::ST_DISPATCH: begin
        cmd.setup1     = run_mode;
        cmd.clear_tare = (stat.mode == atat_pkg::MODE_CLEAR);
      end
      atat_pkg::ST_ROT1:   cmd.step   = 1'b1;
      atat_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
      atat_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
      atat_pkg::ST_SETUP2: cmd.setup2 = 1'b1;
      atat_pkg::ST_ROT2:   cmd.step   = 1'b1;
      atat_pkg::ST_FINISH: cmd.finish = !hold;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/atat_dp.sv
// Datapath with the shared CORDIC unit, gain multiplier, tare offsets and result register.
module atat_dp (
  input  logic               clk,
  input  logic               rst,
  input  atat_pkg::cmd_t     cmd,
  output atat_pkg::stat_t    stat,
  input  logic [1:0]         mode,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  atat_result_if.source      result
);

  localparam int CW = atat_pkg::CW;
  localparam int AW = atat_pkg::AW;
  localparam int PW = atat_pkg::PW;
  localparam int LB = atat_pkg::LO_BITS;
  localparam int MW = LB + atat_pkg::KINV_BITS;

  logic [1:0]                  cur_mode;
  logic [atat_pkg::SAMPLE_BITS-1:0] sx, sy, sz;
  logic signed [CW-1:0]        cx, cy;
  logic signed [AW-1:0]        acc;
  logic                        zero;
  logic [PW-1:0]               prod;
  logic signed [15:0]          roll_raw;
  logic signed [15:0]          pitch_tare, roll_tare;
  logic                        res_valid;
  logic signed [15:0]          res_pitch;
  logic signed [16:0]          res_roll;

  logic signed [CW-1:0] src_a, src_b, pre_x, pre_y, dx, dy, scaled_x;
  logic signed [AW-1:0] pre_acc;
  logic [LB-1:0]        mul_op;
  logic [MW-1:0]        mul_out;
  logic signed [15:0]   pitch_now, roll_now;

  function automatic logic signed [15:0] round_clamp(input logic signed [AW-1:0] a,
                                                     input logic signed [16:0] lim);
    logic signed [AW-1:0] s;
    logic signed [16:0]   r;
    logic signed [16:0]   c;
    s = a + AW'(32768);
    r = s[AW-1:atat_pkg::FRAC_BITS];
    if (r > lim) begin
      c = lim;
    end else if (r < -lim) begin
      c = -lim;
    end else begin
      c = r;
    end
    return c[15:0];
  endfunction

  assign scaled_x = CW'(signed'(sx)) <<< atat_pkg::FRAC_BITS;

  always_comb begin
    if (cmd.setup2) begin
      src_a = CW'(prod >> atat_pkg::KINV_BITS);
      src_b = -scaled_x;
    end else begin
      src_a = CW'(signed'(sz)) <<< atat_pkg::FRAC_BITS;
      src_b = CW'(signed'(sy)) <<< atat_pkg::FRAC_BITS;
    end
  end

  // A vector in the left half plane is turned by a quarter turn before the run.
  always_comb begin
    pre_x   = src_a;
    pre_y   = src_b;
    pre_acc = '0;
    if (src_a < 0) begin
      if (src_b >= 0) begin
        pre_x   = src_b;
        pre_y   = -src_a;
        pre_acc = atat_pkg::QUARTER_TURN;
      end else begin
        pre_x   = -src_b;
        pre_y   = src_a;
        pre_acc = -atat_pkg::QUARTER_TURN;
      end
    end
  end

  assign dx = cy >>> cmd.step_idx;
  assign dy = cx >>> cmd.step_idx;

  assign mul_op  = cmd.mul_hi ? cx[2*LB-1:LB] : cx[LB-1:0];
  assign mul_out = mul_op * atat_pkg::KINV_Q20;

  assign pitch_now = round_clamp(acc, atat_pkg::PITCH_LIMIT);
  assign roll_now  = round_clamp(acc, atat_pkg::ROLL_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mode <= mode;
      sx       <= accel_x[atat_pkg::SAMPLE_BITS-1:0];
      sy       <= accel_y[atat_pkg::SAMPLE_BITS-1:0];
      sz       <= accel_z[atat_pkg::SAMPLE_BITS-1:0];
    end
    if (cmd.setup1 || cmd.setup2) begin
      zero <= (src_a == '0) && (src_b == '0);
      cx   <= pre_x;
      cy   <= pre_y;
      acc  <= pre_acc;
    end else if (cmd.step && !zero) begin
      if (cy >= 0) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        acc <= acc + atat_pkg::atan_entry(cmd.step_idx);
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        acc <= acc - atat_pkg::atan_entry(cmd.step_idx);
      end
    end
    if (cmd.mul_lo) begin
      prod     <= PW'(mul_out);
      roll_raw <= roll_now;
    end else if (cmd.mul_hi) begin
      prod <= prod + (PW'(mul_out) << LB);
    end
    if (cmd.finish && cur_mode == atat_pkg::MODE_MEASURE) begin
      res_pitch <= pitch_now - pitch_tare;
      res_roll  <= 17'(roll_raw) - 17'(roll_tare);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_tare <= '0;
      roll_tare  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.clear_tare) begin
        pitch_tare <= '0;
        roll_tare  <= '0;
      end else if (cmd.finish && cur_mode == atat_pkg::MODE_CAPTURE) begin
        pitch_tare <= pitch_now;
        roll_tare  <= roll_raw;
      end
      if (cmd.finish && cur_mode == atat_pkg::MODE_MEASURE) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign stat.mode     = cur_mode;
  assign stat.res_busy = res_valid && !result.ready;

  assign result.valid       = res_valid;
  assign result.pitch_angle = res_pitch;
  assign result.roll_angle  = res_roll;

endmodule
